/* design/eiphp_pkg.sv */
package eiphp_pkg;

  localparam logic [3:0] PH_LINK    = 4'd0;
  localparam logic [3:0] PH_SNAP    = 4'd1;
  localparam logic [3:0] PH_ARP     = 4'd2;
  localparam logic [3:0] PH_IP4     = 4'd3;
  localparam logic [3:0] PH_IP4OPT  = 4'd4;
  localparam logic [3:0] PH_IP6     = 4'd5;
  localparam logic [3:0] PH_EXT     = 4'd6;
  localparam logic [3:0] PH_EXTSKIP = 4'd7;
  localparam logic [3:0] PH_TCP     = 4'd8;
  localparam logic [3:0] PH_UDP     = 4'd9;
  localparam logic [3:0] PH_ICMP    = 4'd10;
  localparam logic [3:0] PH_DONE    = 4'd11;
  localparam logic [3:0] PH_STOP    = 4'd12;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_TYPE  = 3'd1;
  localparam logic [2:0] ST_SHORT = 3'd2;
  localparam logic [2:0] ST_IHL   = 3'd3;
  localparam logic [2:0] ST_EXT   = 3'd4;
  localparam logic [2:0] ST_TCPOF = 3'd5;
  localparam logic [2:0] ST_NET   = 3'd6;
  localparam logic [2:0] ST_TRN   = 3'd7;

  localparam logic [1:0] LK_ETH2 = 2'd1;
  localparam logic [1:0] LK_8023 = 2'd2;

  localparam logic [2:0] NK_ARP  = 3'd1;
  localparam logic [2:0] NK_RARP = 3'd2;
  localparam logic [2:0] NK_IP4  = 3'd3;
  localparam logic [2:0] NK_IP6  = 3'd4;

  localparam logic [2:0] TK_TCP   = 3'd1;
  localparam logic [2:0] TK_UDP   = 3'd2;
  localparam logic [2:0] TK_ICMP  = 3'd3;
  localparam logic [2:0] TK_ICMP6 = 3'd4;

  localparam logic [15:0] ET_ARP  = 16'h0806;
  localparam logic [15:0] ET_RARP = 16'h8035;
  localparam logic [15:0] ET_IP4  = 16'h0800;
  localparam logic [15:0] ET_IP6  = 16'h86DD;

  localparam logic [7:0] IPP_ICMP  = 8'd1;
  localparam logic [7:0] IPP_TCP   = 8'd6;
  localparam logic [7:0] IPP_UDP   = 8'd17;
  localparam logic [7:0] IPP_ICMP6 = 8'd58;
  localparam logic [7:0] IPP_HOP   = 8'd0;
  localparam logic [7:0] IPP_ROUTE = 8'd43;
  localparam logic [7:0] IPP_DOPT  = 8'd60;

  typedef struct packed {
    logic        kind;
    logic [5:0]  code;
    logic [63:0] value;
    logic [1:0]  link;
    logic [2:0]  net;
    logic [2:0]  trn;
    logic [2:0]  st;
    logic [13:0] poff;
    logic [13:0] plen;
    logic        last;
  } rec_t;

  // bit 6 hit, bits 5:0 field code
  function automatic logic [6:0] fend(input logic [3:0] ph, input logic [7:0] off);
    logic [6:0] r;
    r = 7'd0;
    case (ph)
      PH_LINK: begin
        case (off)
          8'd5:  r = {1'b1, 6'd0};
          8'd11: r = {1'b1, 6'd1};
          8'd13: r = {1'b1, 6'd2};
          default: r = 7'd0;
        endcase
      end
      PH_SNAP: begin
        case (off)
          8'd0: r = {1'b1, 6'd3};
          8'd1: r = {1'b1, 6'd4};
          8'd2: r = {1'b1, 6'd5};
          8'd5: r = {1'b1, 6'd6};
          8'd7: r = {1'b1, 6'd7};
          default: r = 7'd0;
        endcase
      end
      PH_ARP: begin
        case (off)
          8'd1:  r = {1'b1, 6'd8};
          8'd3:  r = {1'b1, 6'd9};
          8'd4:  r = {1'b1, 6'd10};
          8'd5:  r = {1'b1, 6'd11};
          8'd7:  r = {1'b1, 6'd12};
          8'd13: r = {1'b1, 6'd13};
          8'd17: r = {1'b1, 6'd14};
          8'd23: r = {1'b1, 6'd15};
          8'd27: r = {1'b1, 6'd16};
          default: r = 7'd0;
        endcase
      end
      PH_IP4: begin
        case (off)
          8'd0:  r = {1'b1, 6'd17};
          8'd1:  r = {1'b1, 6'd19};
          8'd3:  r = {1'b1, 6'd20};
          8'd5:  r = {1'b1, 6'd21};
          8'd6:  r = {1'b1, 6'd22};
          8'd7:  r = {1'b1, 6'd23};
          8'd8:  r = {1'b1, 6'd24};
          8'd9:  r = {1'b1, 6'd25};
          8'd11: r = {1'b1, 6'd26};
          8'd15: r = {1'b1, 6'd27};
          8'd19: r = {1'b1, 6'd28};
          default: r = 7'd0;
        endcase
      end
      PH_IP6: begin
        case (off)
          8'd0:  r = {1'b1, 6'd18};
          8'd1:  r = {1'b1, 6'd19};
          8'd3:  r = {1'b1, 6'd29};
          8'd5:  r = {1'b1, 6'd30};
          8'd6:  r = {1'b1, 6'd25};
          8'd7:  r = {1'b1, 6'd24};
          8'd15: r = {1'b1, 6'd31};
          8'd23: r = {1'b1, 6'd32};
          8'd31: r = {1'b1, 6'd33};
          8'd39: r = {1'b1, 6'd34};
          default: r = 7'd0;
        endcase
      end
      PH_EXT: begin
        if (off == 8'd1) r = {1'b1, 6'd35};
      end
      PH_TCP: begin
        case (off)
          8'd1:  r = {1'b1, 6'd36};
          8'd3:  r = {1'b1, 6'd37};
          8'd7:  r = {1'b1, 6'd38};
          8'd11: r = {1'b1, 6'd39};
          8'd12: r = {1'b1, 6'd40};
          8'd13: r = {1'b1, 6'd41};
          8'd15: r = {1'b1, 6'd42};
          8'd17: r = {1'b1, 6'd43};
          8'd19: r = {1'b1, 6'd44};
          default: r = 7'd0;
        endcase
      end
      PH_UDP: begin
        case (off)
          8'd1: r = {1'b1, 6'd36};
          8'd3: r = {1'b1, 6'd37};
          8'd5: r = {1'b1, 6'd45};
          8'd7: r = {1'b1, 6'd43};
          default: r = 7'd0;
        endcase
      end
      PH_ICMP: begin
        case (off)
          8'd0: r = {1'b1, 6'd46};
          8'd1: r = {1'b1, 6'd47};
          8'd3: r = {1'b1, 6'd43};
          default: r = 7'd0;
        endcase
      end
      default: r = 7'd0;
    endcase
    return r;
  endfunction

endpackage

/* design/eiphp_parse_core.sv */
module eiphp_parse_core
  import eiphp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 16383
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] data_byte,
  input  logic       frame_end,
  input  logic [3:0] trailer_bytes,
  output logic       f_vld,
  output rec_t       f_rec,
  output logic       s_vld,
  output rec_t       s_rec
);

  localparam int BCW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int HW  = BCW + 1;

  logic [BCW-1:0] bc_r, bc_nxt, ls_r, ls_nxt;
  logic [3:0]     ph_r, ph_nxt;
  logic [63:0]    fa_r, fa_nxt;
  logic [15:0]    np_r, np_nxt;
  logic [10:0]    sk_r, sk_nxt;
  logic [3:0]     hw_r, hw_nxt;
  logic [1:0]     lk_r, lk_nxt;
  logic [2:0]     nk_r, nk_nxt, tk_r, tk_nxt, st_r, st_nxt;
  logic [HW-1:0]  he_r, he_nxt, ap_r, ap_nxt;
  logic           hp_r, hp_nxt;

  logic [BCW-1:0] off, npos, e;
  logic [7:0]     off8;
  logic [63:0]    acc, val, carry;
  logic [6:0]     fe;
  logic [15:0]    id;
  logic [10:0]    skd;
  logic [7:0]     nh;
  logic           go_net, go_trn, go_disp, trn_now;
  logic [2:0]     st_fin;

  always_comb begin
    bc_nxt = bc_r; ls_nxt = ls_r; ph_nxt = ph_r; fa_nxt = fa_r; np_nxt = np_r;
    sk_nxt = sk_r; hw_nxt = hw_r; lk_nxt = lk_r; nk_nxt = nk_r; tk_nxt = tk_r;
    st_nxt = st_r; he_nxt = he_r; ap_nxt = ap_r; hp_nxt = hp_r;
    f_vld = 1'b0; f_rec = '0; s_vld = 1'b0; s_rec = '0;
    go_net = 1'b0; go_trn = 1'b0; go_disp = 1'b0; trn_now = 1'b0;
    off  = bc_r - ls_r;
    off8 = (|(off >> 8)) ? 8'hFF : 8'(off);
    npos = bc_r + BCW'(1);
    acc  = {fa_r[55:0], data_byte};
    fe   = fend(ph_r, off8);
    val  = acc;
    carry = 64'd0;
    id   = acc[15:0];
    skd  = 11'd0;
    nh   = 8'd0;
    e    = '0;
    st_fin = 3'd0;

    if (fire && (bc_r < BCW'(MAX_FRAME_BYTES))) begin
      bc_nxt = npos;
      if (!fe[6]) begin
        fa_nxt = acc;
      end else begin
        if (ph_r == PH_IP4 && off8 == 8'd6) begin
          val = 64'(data_byte[7:5]); carry = 64'(data_byte[4:0]);
        end else if (ph_r == PH_IP6 && off8 == 8'd0) begin
          val = 64'(data_byte[7:4]); carry = 64'(data_byte[3:0]);
        end else if (ph_r == PH_IP6 && off8 == 8'd1) begin
          val = 64'({fa_r[3:0], data_byte[7:4]}); carry = 64'(data_byte[3:0]);
        end else if (ph_r == PH_IP6 && off8 == 8'd3) begin
          val = 64'(acc[19:0]);
        end else if (ph_r == PH_TCP && off8 == 8'd12) begin
          val = 64'({data_byte[7:4], 2'b00}); carry = 64'(data_byte[0]);
        end
        f_vld = 1'b1;
        f_rec.code  = fe[5:0];
        f_rec.value = val;
        f_rec.last  = !frame_end;
        fa_nxt = carry;
      end

      case (ph_r)
        PH_LINK: begin
          if (off8 == 8'd13) begin
            if (id >= 16'd1536) begin
              lk_nxt = LK_ETH2; np_nxt = id; go_net = 1'b1;
            end else if (id <= 16'd1500) begin
              lk_nxt = LK_8023; ls_nxt = npos; fa_nxt = 64'd0; ph_nxt = PH_SNAP;
            end else begin
              st_nxt = ST_TYPE; ph_nxt = PH_STOP;
            end
          end
        end
        PH_SNAP: begin
          if (off8 == 8'd7) begin
            np_nxt = id; go_net = 1'b1;
          end
        end
        PH_ARP: begin
          if (off8 == 8'd27) begin
            he_nxt = HW'(ls_r) + HW'(28); ph_nxt = PH_DONE;
          end
        end
        PH_IP4: begin
          if (off8 == 8'd0) begin
            hw_nxt = data_byte[3:0];
            if (data_byte[3:0] < 4'd5) begin
              st_nxt = ST_IHL; ph_nxt = PH_STOP;
            end
          end else if (off8 == 8'd9) begin
            np_nxt = {8'd0, data_byte};
          end else if (off8 == 8'd19) begin
            if (hw_r > 4'd5) begin
              sk_nxt = 11'({hw_r - 4'd5, 2'b00}); ph_nxt = PH_IP4OPT;
            end else begin
              go_trn = 1'b1;
            end
          end
        end
        PH_IP4OPT: begin
          skd = (sk_r != 11'd0) ? sk_r - 11'd1 : sk_r;
          sk_nxt = skd;
          if (skd == 11'd0) go_trn = 1'b1;
        end
        PH_IP6: begin
          if (off8 == 8'd6) np_nxt = {8'd0, data_byte};
          else if (off8 == 8'd39) go_disp = 1'b1;
        end
        PH_EXT: begin
          if (off8 == 8'd0) begin
            np_nxt = {8'd0, data_byte};
          end else if (off8 == 8'd1) begin
            sk_nxt = {data_byte, 3'b000} + 11'd6; ph_nxt = PH_EXTSKIP;
          end
        end
        PH_EXTSKIP: begin
          skd = (sk_r != 11'd0) ? sk_r - 11'd1 : sk_r;
          sk_nxt = skd;
          if (skd == 11'd0) go_disp = 1'b1;
        end
        PH_TCP: begin
          if (off8 == 8'd12) begin
            hw_nxt = data_byte[7:4];
          end else if (off8 == 8'd19) begin
            he_nxt = HW'(ls_r) + HW'(20);
            ap_nxt = HW'(ls_r) + HW'({hw_r, 2'b00});
            hp_nxt = 1'b1; ph_nxt = PH_DONE;
          end
        end
        PH_UDP: begin
          if (off8 == 8'd7) begin
            he_nxt = HW'(ls_r) + HW'(8); ap_nxt = HW'(ls_r) + HW'(8);
            hp_nxt = 1'b1; ph_nxt = PH_DONE;
          end
        end
        PH_ICMP: begin
          if (off8 == 8'd3) begin
            he_nxt = HW'(ls_r) + HW'(4); ph_nxt = PH_DONE;
          end
        end
        default: ;
      endcase

      nh = np_nxt[7:0];
      if (go_net) begin
        ls_nxt = npos; fa_nxt = 64'd0;
        case (np_nxt)
          ET_ARP:  begin nk_nxt = NK_ARP;  ph_nxt = PH_ARP; end
          ET_RARP: begin nk_nxt = NK_RARP; ph_nxt = PH_ARP; end
          ET_IP4:  begin nk_nxt = NK_IP4;  ph_nxt = PH_IP4; end
          ET_IP6:  begin nk_nxt = NK_IP6;  ph_nxt = PH_IP6; end
          default: begin st_nxt = ST_NET;  ph_nxt = PH_STOP; end
        endcase
      end
      if (go_disp) begin
        if (nh inside {IPP_ICMP, IPP_TCP, IPP_UDP, IPP_ICMP6}) begin
          trn_now = 1'b1;
        end else if (nh inside {IPP_HOP, IPP_ROUTE, IPP_DOPT}) begin
          ls_nxt = npos; fa_nxt = 64'd0; ph_nxt = PH_EXT;
        end else begin
          st_nxt = ST_EXT; ph_nxt = PH_STOP;
        end
      end
      if (go_trn || trn_now) begin
        ls_nxt = npos; fa_nxt = 64'd0;
        case (nh)
          IPP_TCP:   begin tk_nxt = TK_TCP;   ph_nxt = PH_TCP;  end
          IPP_UDP:   begin tk_nxt = TK_UDP;   ph_nxt = PH_UDP;  end
          IPP_ICMP:  begin tk_nxt = TK_ICMP;  ph_nxt = PH_ICMP; end
          IPP_ICMP6: begin tk_nxt = TK_ICMP6; ph_nxt = PH_ICMP; end
          default:   begin st_nxt = ST_TRN;   ph_nxt = PH_STOP; end
        endcase
      end
    end

    if (fire && frame_end) begin
      e = (bc_nxt > BCW'(trailer_bytes)) ? bc_nxt - BCW'(trailer_bytes) : '0;
      st_fin = st_nxt;
      if (st_nxt == ST_OK) begin
        if (ph_nxt != PH_DONE || HW'(e) < he_nxt) st_fin = ST_SHORT;
        else if (tk_nxt == TK_TCP && (hw_nxt < 4'd5 || ap_nxt > HW'(e))) st_fin = ST_TCPOF;
      end
      s_vld = 1'b1;
      s_rec.kind = 1'b1;
      s_rec.link = lk_nxt;
      s_rec.net  = nk_nxt;
      s_rec.trn  = tk_nxt;
      s_rec.st   = st_fin;
      s_rec.last = 1'b1;
      if (st_fin == ST_OK && hp_nxt) begin
        s_rec.poff = 14'(ap_nxt);
        s_rec.plen = 14'(HW'(e) - ap_nxt);
      end
      bc_nxt = '0; ls_nxt = '0; ph_nxt = PH_LINK; fa_nxt = 64'd0; np_nxt = 16'd0;
      sk_nxt = 11'd0; hw_nxt = 4'd0; lk_nxt = 2'd0; nk_nxt = 3'd0; tk_nxt = 3'd0;
      st_nxt = ST_OK; he_nxt = '0; ap_nxt = '0; hp_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r <= '0; ls_r <= '0; ph_r <= PH_LINK; fa_r <= 64'd0; np_r <= 16'd0;
      sk_r <= 11'd0; hw_r <= 4'd0; lk_r <= 2'd0; nk_r <= 3'd0; tk_r <= 3'd0;
      st_r <= ST_OK; he_r <= '0; ap_r <= '0; hp_r <= 1'b0;
    end else begin
      bc_r <= bc_nxt; ls_r <= ls_nxt; ph_r <= ph_nxt; fa_r <= fa_nxt; np_r <= np_nxt;
      sk_r <= sk_nxt; hw_r <= hw_nxt; lk_r <= lk_nxt; nk_r <= nk_nxt; tk_r <= tk_nxt;
      st_r <= st_nxt; he_r <= he_nxt; ap_r <= ap_nxt; hp_r <= hp_nxt;
    end
  end

  a_ls_le_bc: assert property (@(posedge clk) disable iff (!rst_n) ls_r <= bc_r)
    else $error("layer start beyond byte count");
  a_done_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_DONE) |-> (he_r != '0))
    else $error("header end unset in done phase");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && frame_end) |=> (bc_r == '0 && ph_r == PH_LINK))
    else $error("state not cleared after frame end");

endmodule

/* design/eiphp_rec_fifo.sv */
module eiphp_rec_fifo
  import eiphp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic a_vld,
  input  rec_t a_rec,
  input  logic b_vld,
  input  rec_t b_rec,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output rec_t out_rec
);

  rec_t       mem_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] npush;
  logic       pop;

  assign npush     = 2'(a_vld) + 2'(b_vld);
  assign out_valid = (cnt_r != 3'd0);
  assign out_rec   = mem_r[rp_r];
  assign space     = (cnt_r <= 3'd2);
  assign pop       = out_valid && out_ready;

  always_comb begin
    wp_nxt  = wp_r + npush;
    rp_nxt  = rp_r + 2'(pop);
    cnt_nxt = cnt_r + 3'(npush) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (a_vld) mem_r[wp_r] <= a_rec;
    if (b_vld) mem_r[wp_r + 2'(a_vld)] <= b_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 2'd0; rp_r <= 2'd0; cnt_r <= 3'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

  a_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("record queue overflow");
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    (npush != 2'd0) |-> (cnt_r <= 3'd2))
    else $error("request pushed without room");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'd0 || cnt_r == 3'd4) |-> (wp_r == rp_r))
    else $error("pointer and count disagree");

endmodule

/* design/ethernet_ip_header_parser.sv */
// Streaming Ethernet / IP header parser, one frame byte per request.
// Input channel: in_data_byte with in_frame_end on the final byte, accepted
// when in_valid and in_ready are both high. Each byte that completes a header
// field yields a field record; the final byte also yields a summary record
// (layer kinds, status, payload offset and length), with out_last marking the
// final record caused by that byte.
// Configuration: cfg_wr_en writes cfg_wr_data as the trailer length at once;
// write it only while the block is idle. Reset value 4.
// Records are written into a four-entry record queue as their byte is accepted.
// Throughput: one byte per cycle while in_ready is high; the frame-end byte
// queues up to two records, which drain one per cycle while out_ready is high.
// in_ready is high while the queue has room for two records.
// Reset (rst_n low, synchronous) clears the parse state and empties the queue.
// When the receiver stalls, records hold in the queue and in_ready drops once
// fewer than two entries are free.
module ethernet_ip_header_parser
  import eiphp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 16383
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_record_kind,
  output logic [5:0]  out_field_code,
  output logic [63:0] out_field_value,
  output logic [1:0]  out_link_kind,
  output logic [2:0]  out_network_kind,
  output logic [2:0]  out_transport_kind,
  output logic [2:0]  out_status,
  output logic [13:0] out_payload_offset,
  output logic [13:0] out_payload_length,
  output logic        out_last
);

  logic [3:0] tb_r;
  logic       fire, f_vld, s_vld, space;
  rec_t       f_rec, s_rec, o_rec;

  assign fire     = in_valid && in_ready;
  assign in_ready = space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tb_r <= 4'd4;
    end else if (cfg_wr_en) begin
      tb_r <= cfg_wr_data;
    end
  end

  eiphp_parse_core #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_core (
    .clk(clk), .rst_n(rst_n), .fire(fire), .data_byte(in_data_byte),
    .frame_end(in_frame_end), .trailer_bytes(tb_r),
    .f_vld(f_vld), .f_rec(f_rec), .s_vld(s_vld), .s_rec(s_rec)
  );

  eiphp_rec_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .a_vld(f_vld || s_vld), .a_rec(f_vld ? f_rec : s_rec),
    .b_vld(f_vld && s_vld), .b_rec(s_rec),
    .space(space), .out_valid(out_valid), .out_ready(out_ready), .out_rec(o_rec)
  );

  assign out_record_kind    = o_rec.kind;
  assign out_field_code     = o_rec.code;
  assign out_field_value    = o_rec.value;
  assign out_link_kind      = o_rec.link;
  assign out_network_kind   = o_rec.net;
  assign out_transport_kind = o_rec.trn;
  assign out_status         = o_rec.st;
  assign out_payload_offset = o_rec.poff;
  assign out_payload_length = o_rec.plen;
  assign out_last           = o_rec.last;

endmodule

/* tb/eiphp_checker.sv */
module eiphp_checker
  import eiphp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 16383
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_record_kind,
  input  logic [5:0]  out_field_code,
  input  logic [63:0] out_field_value,
  input  logic [1:0]  out_link_kind,
  input  logic [2:0]  out_network_kind,
  input  logic [2:0]  out_transport_kind,
  input  logic [2:0]  out_status,
  input  logic [13:0] out_payload_offset,
  input  logic [13:0] out_payload_length,
  input  logic        out_last,
  output int          fail_count,
  output int          pending,
  output int          records_seen,
  output int          summaries_seen
);

  typedef enum logic [5:0] {
    F_DST_MAC, F_SRC_MAC, F_TYPE_LEN, F_DSAP, F_SSAP, F_CTRL, F_SNAP_ORG, F_SNAP_TYPE,
    F_HW_TYPE, F_PROTO_TYPE, F_HW_LEN, F_PROTO_LEN, F_ARP_OP, F_SND_MAC, F_SND_IP,
    F_TGT_MAC, F_TGT_IP, F_VER_IHL, F_IP6_VER, F_TOS, F_TOT_LEN, F_IDENT, F_FLAGS,
    F_FRAG_OFF, F_TTL, F_PROTO, F_HDR_CSUM, F_IP4_SRC, F_IP4_DST, F_FLOW, F_PL_LEN,
    F_SRC6_HI, F_SRC6_LO, F_DST6_HI, F_DST6_LO, F_EXT_HDR, F_SPORT, F_DPORT, F_SEQ,
    F_ACK, F_DOFF, F_TCP_FLAGS, F_WINDOW, F_CSUM, F_URG, F_UDP_LEN, F_ICMP_TYPE,
    F_ICMP_CODE
  } field_e;

  rec_t        records_due[$];
  int unsigned trailer, bcount, lstart, skip, hwords, hdr_end, app_start;
  logic [3:0]  phase;
  logic [63:0] accum;
  logic [15:0] nproto;
  logic [1:0]  lk;
  logic [2:0]  nk, tk, st;
  bit          has_pl;
  int          step_recs;

  function automatic int field_at(logic [3:0] ph, int unsigned off);
    case (ph)
      PH_LINK: case (off)
        5: return F_DST_MAC;  11: return F_SRC_MAC;  13: return F_TYPE_LEN;
        default: return -1;
      endcase
      PH_SNAP: case (off)
        0: return F_DSAP;  1: return F_SSAP;  2: return F_CTRL;
        5: return F_SNAP_ORG;  7: return F_SNAP_TYPE;
        default: return -1;
      endcase
      PH_ARP: case (off)
        1: return F_HW_TYPE;  3: return F_PROTO_TYPE;  4: return F_HW_LEN;
        5: return F_PROTO_LEN;  7: return F_ARP_OP;  13: return F_SND_MAC;
        17: return F_SND_IP;  23: return F_TGT_MAC;  27: return F_TGT_IP;
        default: return -1;
      endcase
      PH_IP4: case (off)
        0: return F_VER_IHL;  1: return F_TOS;  3: return F_TOT_LEN;  5: return F_IDENT;
        6: return F_FLAGS;  7: return F_FRAG_OFF;  8: return F_TTL;  9: return F_PROTO;
        11: return F_HDR_CSUM;  15: return F_IP4_SRC;  19: return F_IP4_DST;
        default: return -1;
      endcase
      PH_IP6: case (off)
        0: return F_IP6_VER;  1: return F_TOS;  3: return F_FLOW;  5: return F_PL_LEN;
        6: return F_PROTO;  7: return F_TTL;  15: return F_SRC6_HI;  23: return F_SRC6_LO;
        31: return F_DST6_HI;  39: return F_DST6_LO;
        default: return -1;
      endcase
      PH_EXT: return (off == 1) ? F_EXT_HDR : -1;
      PH_TCP: case (off)
        1: return F_SPORT;  3: return F_DPORT;  7: return F_SEQ;  11: return F_ACK;
        12: return F_DOFF;  13: return F_TCP_FLAGS;  15: return F_WINDOW;
        17: return F_CSUM;  19: return F_URG;
        default: return -1;
      endcase
      PH_UDP: case (off)
        1: return F_SPORT;  3: return F_DPORT;  5: return F_UDP_LEN;  7: return F_CSUM;
        default: return -1;
      endcase
      PH_ICMP: case (off)
        0: return F_ICMP_TYPE;  1: return F_ICMP_CODE;  3: return F_CSUM;
        default: return -1;
      endcase
      default: return -1;
    endcase
  endfunction

  task automatic clear_frame();
    bcount = 0; phase = PH_LINK; accum = '0; lstart = 0; nproto = '0; skip = 0;
    hwords = 0; lk = '0; nk = '0; tk = '0; st = ST_OK; hdr_end = 0; app_start = 0;
    has_pl = 0;
  endtask

  task automatic push_record(logic kind, logic [5:0] code, logic [63:0] val,
                             int unsigned po, int unsigned pl);
    rec_t r;
    r = '0;
    r.kind = kind; r.code = code; r.value = val;
    if (kind) begin
      r.link = lk; r.net = nk; r.trn = tk; r.st = st;
      r.poff = po[13:0]; r.plen = pl[13:0];
    end
    records_due.push_back(r);
    step_recs++;
  endtask

  task automatic halt(logic [2:0] s);
    st = s; phase = PH_STOP;
  endtask

  task automatic start_network(int unsigned s);
    lstart = s; accum = '0;
    case (nproto)
      ET_ARP:  begin nk = NK_ARP;  phase = PH_ARP; end
      ET_RARP: begin nk = NK_RARP; phase = PH_ARP; end
      ET_IP4:  begin nk = NK_IP4;  phase = PH_IP4; end
      ET_IP6:  begin nk = NK_IP6;  phase = PH_IP6; end
      default: halt(ST_NET);
    endcase
  endtask

  task automatic start_transport(int unsigned s);
    lstart = s; accum = '0;
    case (nproto[7:0])
      IPP_TCP:   begin tk = TK_TCP;   phase = PH_TCP;  end
      IPP_UDP:   begin tk = TK_UDP;   phase = PH_UDP;  end
      IPP_ICMP:  begin tk = TK_ICMP;  phase = PH_ICMP; end
      IPP_ICMP6: begin tk = TK_ICMP6; phase = PH_ICMP; end
      default: halt(ST_TRN);
    endcase
  endtask

  task automatic next_ip6_header(int unsigned s);
    logic [7:0] nh;
    nh = nproto[7:0];
    if (nh == IPP_ICMP || nh == IPP_TCP || nh == IPP_UDP || nh == IPP_ICMP6) begin
      start_transport(s);
    end else if (nh == IPP_HOP || nh == IPP_ROUTE || nh == IPP_DOPT) begin
      lstart = s; accum = '0; phase = PH_EXT;
    end else begin
      halt(ST_EXT);
    end
  endtask

  task automatic parse_byte(logic [7:0] b);
    int unsigned off, nxt;
    logic [63:0] acc, val, carry;
    int code;
    off = bcount - lstart;
    nxt = bcount + 1;
    acc = {accum[55:0], b};
    code = field_at(phase, off);
    if (code < 0) begin
      accum = acc;
    end else begin
      val = acc; carry = '0;
      if (phase == PH_IP4 && off == 6) begin
        val = b[7:5]; carry = b[4:0];
      end else if (phase == PH_IP6 && off == 0) begin
        val = b[7:4]; carry = b[3:0];
      end else if (phase == PH_IP6 && off == 1) begin
        val = {accum[3:0], b[7:4]}; carry = b[3:0];
      end else if (phase == PH_IP6 && off == 3) begin
        val = acc[19:0];
      end else if (phase == PH_TCP && off == 12) begin
        val = b[7:4] * 4; carry = b[0];
      end
      push_record(1'b0, code[5:0], val, 0, 0);
      accum = carry;
    end
    case (phase)
      PH_LINK: if (off == 13) begin
        if (acc[15:0] >= 16'd1536) begin
          lk = LK_ETH2; nproto = acc[15:0]; start_network(nxt);
        end else if (acc[15:0] <= 16'd1500) begin
          lk = LK_8023; lstart = nxt; accum = '0; phase = PH_SNAP;
        end else begin
          halt(ST_TYPE);
        end
      end
      PH_SNAP: if (off == 7) begin
        nproto = acc[15:0]; start_network(nxt);
      end
      PH_ARP: if (off == 27) begin
        hdr_end = lstart + 28; phase = PH_DONE;
      end
      PH_IP4: begin
        if (off == 0) begin
          hwords = b[3:0];
          if (hwords < 5) halt(ST_IHL);
        end else if (off == 9) begin
          nproto = b;
        end else if (off == 19) begin
          if (hwords > 5) begin
            skip = (hwords - 5) * 4; phase = PH_IP4OPT;
          end else begin
            start_transport(nxt);
          end
        end
      end
      PH_IP4OPT: begin
        if (skip > 0) skip--;
        if (skip == 0) start_transport(nxt);
      end
      PH_IP6: begin
        if (off == 6) nproto = b;
        else if (off == 39) next_ip6_header(nxt);
      end
      PH_EXT: begin
        if (off == 0) begin
          nproto = b;
        end else if (off == 1) begin
          skip = b * 8 + 6; phase = PH_EXTSKIP;
        end
      end
      PH_EXTSKIP: begin
        if (skip > 0) skip--;
        if (skip == 0) next_ip6_header(nxt);
      end
      PH_TCP: begin
        if (off == 12) begin
          hwords = b[7:4];
        end else if (off == 19) begin
          hdr_end = lstart + 20; app_start = lstart + hwords * 4;
          has_pl = 1; phase = PH_DONE;
        end
      end
      PH_UDP: if (off == 7) begin
        hdr_end = lstart + 8; app_start = hdr_end; has_pl = 1; phase = PH_DONE;
      end
      PH_ICMP: if (off == 3) begin
        hdr_end = lstart + 4; phase = PH_DONE;
      end
      default: ;
    endcase
  endtask

  task automatic predict_request(logic [7:0] b, logic fe);
    int unsigned e, po, pl;
    rec_t r;
    step_recs = 0;
    if (bcount < MAX_FRAME_BYTES) begin
      parse_byte(b);
      bcount++;
    end
    if (fe) begin
      e = (bcount > trailer) ? bcount - trailer : 0;
      po = 0; pl = 0;
      if (st == ST_OK) begin
        if (phase != PH_DONE || e < hdr_end) st = ST_SHORT;
        else if (tk == TK_TCP && (hwords < 5 || app_start > e)) st = ST_TCPOF;
      end
      if (st == ST_OK && has_pl) begin
        po = app_start; pl = e - app_start;
      end
      push_record(1'b1, '0, '0, po, pl);
      clear_frame();
    end
    if (step_recs > 0) begin
      r = records_due.pop_back();
      r.last = 1'b1;
      records_due.push_back(r);
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_record();
    rec_t w;
    if (records_due.size() == 0) begin
      $error("record with none pending: kind %0b code %0d value %0h",
             out_record_kind, out_field_code, out_field_value);
      fail_count++;
    end else begin
      w = records_due.pop_front();
      check_field("record_kind", w.kind, out_record_kind);
      check_field("field_code", w.code, out_field_code);
      check_field("field_value", w.value, out_field_value);
      check_field("link_kind", w.link, out_link_kind);
      check_field("network_kind", w.net, out_network_kind);
      check_field("transport_kind", w.trn, out_transport_kind);
      check_field("status", w.st, out_status);
      check_field("payload_offset", w.poff, out_payload_offset);
      check_field("payload_length", w.plen, out_payload_length);
      check_field("last", w.last, out_last);
    end
    records_seen++;
    if (out_record_kind) summaries_seen++;
  endtask

  initial begin
    fail_count = 0; records_seen = 0; summaries_seen = 0; trailer = 4; pending = 0;
    clear_frame();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      trailer = 4;
      clear_frame();
      records_due.delete();
    end else begin
      if (cfg_wr_en) trailer = cfg_wr_data;
      if (in_valid && in_ready) predict_request(in_data_byte, in_frame_end);
      if (out_valid && out_ready) check_record();
    end
    pending = records_due.size();
  end

endmodule

/* tb/tb_top.sv */
module tb_top
  import eiphp_pkg::*;
;

  localparam int LIMIT = 800000;

  logic        clk, rst_n;
  logic        in_valid, in_ready, in_frame_end;
  logic [7:0]  in_data_byte;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;
  logic        out_valid, out_ready, out_record_kind, out_last;
  logic [5:0]  out_field_code;
  logic [63:0] out_field_value;
  logic [1:0]  out_link_kind;
  logic [2:0]  out_network_kind, out_transport_kind, out_status;
  logic [13:0] out_payload_offset, out_payload_length;

  int          fail_count, pending, records_seen, summaries_seen;
  int          cycles, idle_pct, stall_pct, bytes_sent, frames_sent;
  logic [7:0]  frame[$];

  ethernet_ip_header_parser dut (.*);

  eiphp_checker chk (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic add_rand(int n);
    repeat (n) frame.push_back(8'($urandom_range(255)));
  endtask

  task automatic add16(logic [15:0] v);
    frame.push_back(v[15:8]);
    frame.push_back(v[7:0]);
  endtask

  function automatic logic [7:0] pick_transport(bit v6);
    int r;
    r = $urandom_range(99);
    if (r < 35) return IPP_TCP;
    if (r < 65) return IPP_UDP;
    if (r < 88) return v6 ? IPP_ICMP6 : IPP_ICMP;
    if (r < 94) return v6 ? IPP_ICMP : IPP_ICMP6;
    return 8'($urandom_range(255));
  endfunction

  task automatic build_transport(logic [7:0] p);
    int doff;
    if (p == IPP_TCP) begin
      doff = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(5, 8);
      add_rand(12);
      frame.push_back({doff[3:0], 4'($urandom_range(15))});
      add_rand(7);
      if (doff > 5 && $urandom_range(3) != 0) add_rand((doff - 5) * 4);
    end else if (p == IPP_UDP) begin
      add_rand(8);
    end else if (p == IPP_ICMP || p == IPP_ICMP6) begin
      add_rand(4);
    end
  endtask

  task automatic build_frame();
    int r, ihl, n_ext, cut;
    logic [15:0] etype;
    logic [7:0] proto;
    frame.delete();
    if ($urandom_range(19) == 0) begin
      add_rand($urandom_range(1, 30));
      return;
    end
    add_rand(12);
    r = $urandom_range(99);
    if (r < 6) begin
      add16(16'($urandom_range(1501, 1535)));
      add_rand($urandom_range(0, 10));
      return;
    end
    r = $urandom_range(99);
    if (r < 25) etype = ET_IP4;
    else if (r < 50) etype = ET_IP6;
    else if (r < 65) etype = ET_ARP;
    else if (r < 80) etype = ET_RARP;
    else if (r < 85) etype = 16'($urandom_range(1536, 65535));
    else etype = ($urandom_range(1) == 0) ? ET_IP4 : ET_IP6;
    if ($urandom_range(3) == 0) begin
      add16(16'($urandom_range(0, 1500)));
      frame.push_back(8'hAA); frame.push_back(8'hAA); frame.push_back(8'h03);
      add_rand(3);
    end
    add16(etype);
    if (etype == ET_ARP || etype == ET_RARP) begin
      add_rand(28);
    end else if (etype == ET_IP4) begin
      ihl = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(5, 7);
      proto = pick_transport(0);
      frame.push_back({4'($urandom_range(15)), ihl[3:0]});
      add_rand(8);
      frame.push_back(proto);
      add_rand(10);
      if (ihl > 5) add_rand((ihl - 5) * 4);
      build_transport(proto);
    end else if (etype == ET_IP6) begin
      n_ext = $urandom_range(2);
      proto = (n_ext > 0) ? (($urandom_range(2) == 0) ? IPP_HOP :
              ($urandom_range(1) == 0) ? IPP_ROUTE : IPP_DOPT) : pick_transport(1);
      add_rand(6);
      frame.push_back(proto);
      add_rand(33);
      for (int i = 0; i < n_ext; i++) begin
        r = $urandom_range(1);
        proto = (i + 1 < n_ext) ? IPP_DOPT : pick_transport(1);
        if ($urandom_range(15) == 0) proto = 8'($urandom_range(255));
        frame.push_back(proto);
        frame.push_back(r[7:0]);
        add_rand(r * 8 + 6);
      end
      build_transport(proto);
    end
    add_rand($urandom_range(0, 12));
    add_rand($urandom_range(0, 8));
    if ($urandom_range(9) == 0) begin
      cut = $urandom_range(1, frame.size());
      while (frame.size() > cut) void'(frame.pop_back());
    end
  endtask

  task automatic send_request(logic [7:0] b, logic fe);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_frame_end <= fe;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_request(frame[i], i == frame.size() - 1);
    in_valid <= 1'b0;
    frames_sent++;
  endtask

  task automatic write_trailer(logic [3:0] v);
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int quota;
    logic [3:0] trailers[4];
    int idles[4], stalls[4];
    cycles = 0; bytes_sent = 0; frames_sent = 0;
    idle_pct = 0; stall_pct = 0;
    rst_n = 1'b0; in_valid = 1'b0; in_data_byte = '0; in_frame_end = 1'b0;
    cfg_wr_en = 1'b0; cfg_wr_data = '0; out_ready = 1'b1;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-byte frame, then two frames with a bad length field
    frame = '{8'hFF};
    send_frame();
    frame.delete();
    add_rand(12);
    add16(16'd1501);
    send_frame();
    frame.delete();
    add_rand(12);
    add16(16'd1535);
    frame.push_back(8'h00);
    send_frame();

    trailers = '{4'd0, 4'd8, 4'd15, 4'($urandom_range(1, 7))};
    idles = '{0, 68, 0, 26};
    stalls = '{0, 0, 68, 26};
    for (int ph = 0; ph < 4; ph++) begin
      write_trailer(trailers[ph]);
      idle_pct = idles[ph];
      stall_pct = stalls[ph];
      quota = bytes_sent + 300;
      while (bytes_sent < quota) begin
        build_frame();
        send_frame();
      end
    end

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Sent %0d frames (%0d bytes); checked %0d records, %0d frame summaries,",
             frames_sent, bytes_sent, records_seen, summaries_seen);
    $display("over several trailer lengths with sender gaps and receiver stalls.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
